### rtl/core/command_apdu_parser_unit_assert.svh
// assertion macros shared by the command apdu parser modules
`ifndef COMMAND_APDU_PARSER_UNIT_ASSERT_SVH
`define COMMAND_APDU_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cap_pkg.sv
// types, codes and constants of the command apdu parser
package cap_pkg;

    // result fifo depth, a power of two of at least four
    localparam int CAP_FIFO_DEPTH = 8;

    // packed result bus width: 83 bits of fields filled up to whole bytes
    localparam int CAP_M_TDATA_W = 88;
    localparam int CAP_S_TDATA_W = 8;

    // decoded two-byte le of zero
    localparam logic [16:0] CAP_LE_ZERO_LEN = 17'h10000;

    // item kinds on tuser
    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // status codes
    localparam logic STATUS_NONE      = 1'b0;
    localparam logic STATUS_BAD_CLASS = 1'b1;

    // parse phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LC,
        PH_LCX,
        PH_BODY,
        PH_LE,
        PH_SKIP
    } phase_t;

    // le decode state
    typedef struct packed {
        logic [1:0]  seen;
        logic [16:0] len;
    } le_t;

    // one result item
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  body_byte;
        logic [15:0] body_index;
        logic        parse_ok;
        logic        status_code;
        logic [7:0]  instruction;
        logic [7:0]  param_one;
        logic [7:0]  param_two;
        logic [15:0] body_length;
        logic [16:0] max_response_len;
        logic        is_last;
    } result_t;

    // parse stage to result fifo
    typedef struct packed {
        logic    busy;
        logic    push0;
        logic    push1;
        result_t item0;
        result_t item1;
    } stage_t;

endpackage

### rtl/core/cap_parse.sv
// input register and byte-wise apdu parse state, one accepted request per cycle
module cap_parse
    import cap_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_accept,
    input  logic [7:0] s_byte,
    input  logic       s_last,
    output stage_t     stage
);

    `include "command_apdu_parser_unit_assert.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic [2:0]  byte_pos_reg,  byte_pos_next;
    phase_t      phase_reg,     phase_next;
    logic        class_ok_reg,  class_ok_next;
    logic [23:0] header_reg,    header_next;
    logic [15:0] held_reg,      held_next;
    logic [15:0] declared_reg,  declared_next;
    logic [15:0] body_count_reg, body_count_next;
    le_t         le_reg,        le_next;

    logic        ok;
    logic        status;
    logic        emit;
    logic [15:0] emit_index;
    result_t     body_item;
    result_t     summary_item;

    // one le byte into the decode
    function automatic le_t take_le(le_t cur, logic [7:0] b);
        le_t         r;
        logic [15:0] word;
        r    = cur;
        word = {cur.len[7:0], b};
        case (cur.seen)
            2'd0: begin
                r.len  = {9'b0, b};
                r.seen = 2'd1;
            end
            2'd1: begin
                r.len  = (word == 16'h0) ? CAP_LE_ZERO_LEN : {1'b0, word};
                r.seen = 2'd2;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept;
        end
        if (s_accept) begin
            in_byte_reg <= s_byte;
            in_last_reg <= s_last;
        end
    end

    // next parse state and result items
    always_comb begin
        byte_pos_next   = byte_pos_reg;
        phase_next      = phase_reg;
        class_ok_next   = class_ok_reg;
        header_next     = header_reg;
        held_next       = held_reg;
        declared_next   = declared_reg;
        body_count_next = body_count_reg;
        le_next         = le_reg;
        ok              = 1'b0;
        status          = STATUS_NONE;
        emit            = 1'b0;
        emit_index      = body_count_reg;

        case (phase_reg)
            PH_HEADER: begin
                if (byte_pos_reg == 3'd0) begin
                    class_ok_next = (in_byte_reg == 8'h00);
                end else begin
                    header_next = {header_reg[15:0], in_byte_reg};
                end
                if (byte_pos_reg == 3'd3) begin
                    byte_pos_next = 3'd0;
                    phase_next    = class_ok_reg ? PH_LC : PH_SKIP;
                    if (in_last_reg) begin
                        ok     = class_ok_reg;
                        status = class_ok_reg ? STATUS_NONE : STATUS_BAD_CLASS;
                    end
                end else begin
                    byte_pos_next = byte_pos_reg + 3'd1;
                end
            end
            PH_LC: begin
                if (in_byte_reg != 8'h00) begin
                    declared_next = {8'h00, in_byte_reg};
                    phase_next    = PH_BODY;
                end else begin
                    phase_next = PH_LCX;
                    ok         = in_last_reg;
                end
            end
            PH_LCX: begin
                if (byte_pos_reg == 3'd0) begin
                    held_next     = {8'h00, in_byte_reg};
                    byte_pos_next = 3'd1;
                    if (in_last_reg) begin
                        le_next = take_le(le_reg, in_byte_reg);
                        ok      = 1'b1;
                    end
                end else if (byte_pos_reg == 3'd1) begin
                    held_next     = {held_reg[7:0], in_byte_reg};
                    byte_pos_next = 3'd2;
                    if (in_last_reg) begin
                        le_next = take_le(take_le(le_reg, held_reg[7:0]), in_byte_reg);
                        ok      = 1'b1;
                    end
                end else begin
                    declared_next = held_reg;
                    byte_pos_next = 3'd0;
                    if (held_reg == 16'h0000) begin
                        phase_next = PH_LE;
                        le_next    = take_le(le_reg, in_byte_reg);
                        ok         = in_last_reg;
                    end else begin
                        phase_next      = PH_BODY;
                        emit            = 1'b1;
                        body_count_next = body_count_reg + 16'd1;
                        if (body_count_next == held_reg) begin
                            phase_next = PH_LE;
                        end
                        ok = in_last_reg && (phase_next == PH_LE);
                    end
                end
            end
            PH_BODY: begin
                emit            = 1'b1;
                body_count_next = body_count_reg + 16'd1;
                if (body_count_next == declared_reg) begin
                    phase_next = PH_LE;
                end
                ok = in_last_reg && (phase_next == PH_LE);
            end
            PH_LE: begin
                le_next = take_le(le_reg, in_byte_reg);
                ok      = in_last_reg;
            end
            default: begin
                status = STATUS_BAD_CLASS;
            end
        endcase

        // body item
        body_item            = '0;
        body_item.item_kind  = KIND_BODY;
        body_item.body_byte  = in_byte_reg;
        body_item.body_index = emit_index;

        // summary item from the updated state
        summary_item             = '0;
        summary_item.item_kind   = KIND_SUMMARY;
        summary_item.parse_ok    = ok;
        summary_item.status_code = status;
        summary_item.is_last     = 1'b1;
        if (ok) begin
            summary_item.instruction      = header_next[23:16];
            summary_item.param_one        = header_next[15:8];
            summary_item.param_two        = header_next[7:0];
            summary_item.body_length      = declared_next;
            summary_item.max_response_len = le_next.len;
        end

        // end of apdu returns all state to reset values
        if (in_last_reg) begin
            byte_pos_next   = 3'd0;
            phase_next      = PH_HEADER;
            class_ok_next   = 1'b0;
            header_next     = '0;
            held_next       = '0;
            declared_next   = '0;
            body_count_next = '0;
            le_next         = '0;
        end

        // pushes towards the fifo, body item always first
        stage.busy  = in_valid_reg;
        stage.push0 = in_valid_reg && (emit || in_last_reg);
        stage.push1 = in_valid_reg && emit && in_last_reg;
        stage.item0 = emit ? body_item : summary_item;
        stage.item1 = summary_item;
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg   <= 3'd0;
            phase_reg      <= PH_HEADER;
            class_ok_reg   <= 1'b0;
            header_reg     <= '0;
            held_reg       <= '0;
            declared_reg   <= '0;
            body_count_reg <= '0;
            le_reg         <= '0;
        end else if (in_valid_reg) begin
            byte_pos_reg   <= byte_pos_next;
            phase_reg      <= phase_next;
            class_ok_reg   <= class_ok_next;
            header_reg     <= header_next;
            held_reg       <= held_next;
            declared_reg   <= declared_next;
            body_count_reg <= body_count_next;
            le_reg         <= le_next;
        end
    end

    // a second push only ever carries the summary behind a body byte
    `CAP_ASSERT_NOW(a_push1_order, stage.push1, stage.push0 && (stage.item0.item_kind == KIND_BODY) && (stage.item1.item_kind == KIND_SUMMARY), "second push is not summary behind body")

    // after an end of apdu the parser is back at the header
    `CAP_ASSERT_NEXT(a_reset_after_last, in_valid_reg && in_last_reg, (phase_reg == PH_HEADER) && (byte_pos_reg == 3'd0) && (body_count_reg == 16'd0), "state not cleared after end of apdu")

    // header and lc extension positions stay below four
    `CAP_ASSERT_NOW(a_pos_range, in_valid_reg, byte_pos_reg <= 3'd3, "byte position out of range")

endmodule

### rtl/core/cap_out_fifo.sv
// result fifo taking up to two items per cycle, with credit towards the input
module cap_out_fifo
    import cap_pkg::*;
#(
    parameter int DEPTH = CAP_FIFO_DEPTH
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  stage_t  stage,
    output logic    can_accept,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_item
);

    `include "command_apdu_parser_unit_assert.svh"

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = PTR_W + 1;

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [COUNT_W:0]   need;
    logic               pop;

    // read side
    assign m_valid = (count_reg != '0);
    assign m_item  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // room for the two items of the parse stage and two of one more request
    always_comb begin
        need       = {1'b0, count_reg} + (stage.busy ? (COUNT_W+1)'(2) : '0);
        can_accept = (need <= (COUNT_W+1)'(DEPTH - 2));
    end

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (stage.push1) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(2);
        end else if (stage.push0) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + COUNT_W'(stage.push0) + COUNT_W'(stage.push1)
                      - COUNT_W'(pop);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (stage.push0) begin
            entry_reg[wr_ptr_reg] <= stage.item0;
        end
        if (stage.push1) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= stage.item1;
        end
    end

    // occupancy never passes the depth
    `CAP_ASSERT_NOW(a_count_max, 1'b1, count_reg <= COUNT_W'(DEPTH), "fifo count above depth")

    // credit holds room for a busy parse stage
    `CAP_ASSERT_NOW(a_credit, stage.busy, count_reg <= COUNT_W'(DEPTH - 2), "no room for parse stage pushes")

    // a waiting item is not lost
    `CAP_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && (rd_ptr_reg == $past(rd_ptr_reg)), "waiting result dropped")

endmodule

### rtl/core/command_apdu_parser_unit.sv
// top level of the command apdu parser: byte stream in, body and summary items out
//
//  channel   dir  tdata                                   tuser      tlast
//  s_axis    in   rx_byte                                 -          end_of_apdu
//  m_axis    out  body byte, index, ok, status, header,   item_kind  is_last
//                 lc, le
//
// one byte is taken per cycle while s_axis_tready is high; a byte passes the
// input register, the parse logic and then the result fifo.
// a final byte that also carries body data yields two results, body item
// first; input stalls when the result fifo lacks room for two results
// of the byte in the parse stage plus two of the next request.
// aresetn is synchronous and returns the parser to the header phase.
// m_axis_tready low fills the fifo and then holds s_axis_tready low.
module command_apdu_parser_unit
    import cap_pkg::*;
#(
    parameter int FIFO_DEPTH = CAP_FIFO_DEPTH
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [CAP_S_TDATA_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [7:0] body_byte, [23:8] body_index, [24] parse_ok, [25] status_code,
    // [33:26] instruction, [41:34] param_one, [49:42] param_two,
    // [65:50] body_length, [82:66] max_response_len, [87:83] zero
    output logic [CAP_M_TDATA_W-1:0] m_axis_tdata,
    output logic                     m_axis_tuser,   // [0] item_kind
    output logic                     m_axis_tlast
);

    stage_t  stage;
    logic    can_accept;
    result_t out_item;

    // input request handshake
    assign s_axis_tready = can_accept;

    // parse stage
    cap_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_accept (s_axis_tvalid && s_axis_tready),
        .s_byte   (s_axis_tdata),
        .s_last   (s_axis_tlast),
        .stage    (stage)
    );

    // result fifo
    cap_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stage      (stage),
        .can_accept (can_accept),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_item     (out_item)
    );

    // result packing
    assign m_axis_tdata = {5'b0, out_item.max_response_len, out_item.body_length,
                           out_item.param_two, out_item.param_one, out_item.instruction,
                           out_item.status_code, out_item.parse_ok, out_item.body_index,
                           out_item.body_byte};
    assign m_axis_tuser = out_item.item_kind;
    assign m_axis_tlast = out_item.is_last;

endmodule

### bench/testbench.sv
// self-checking bench for the command apdu parser: directed and random apdus
`timescale 1ns / 100ps

module testbench;
    import cap_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_BYTES = 1270;

    // clock and reset
    logic aclk;
    logic aresetn = 1'b0;

    // request side
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [CAP_S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                     s_axis_tlast  = 1'b0;

    // result side
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [CAP_M_TDATA_W-1:0] m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     m_axis_tlast;

    command_apdu_parser_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // idle percentages for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // counters
    int bytes_sent     = 0;
    int apdus_sent     = 0;
    int body_checked   = 0;
    int summary_ok     = 0;
    int summary_failed = 0;
    int mismatches     = 0;
    int stall_cycles   = 0;

    // apdu under construction
    logic [7:0] frame[$];

    // results still owed by the parser
    result_t pending_results[$];

    // append one byte to the apdu under construction
    task automatic add_byte(input logic [7:0] b);
        frame = {frame, b};
    endtask

    // record one result the parser now owes
    task automatic owe_result(input result_t r);
        pending_results = {pending_results, r};
    endtask

    // parser model state
    logic [2:0]  m_pos;
    phase_t      m_phase;
    logic        m_class_ok;
    logic [23:0] m_hdr;
    logic [15:0] m_held;
    logic [15:0] m_lc;
    logic [15:0] m_count;
    logic [16:0] m_le;
    logic [1:0]  m_le_seen;

    task automatic clear_parser_state();
        m_pos      = '0;
        m_phase    = PH_HEADER;
        m_class_ok = 1'b0;
        m_hdr      = '0;
        m_held     = '0;
        m_lc       = '0;
        m_count    = '0;
        m_le       = '0;
        m_le_seen  = '0;
    endtask

    // le decode: one byte as is, two bytes big endian with zero meaning 65536
    task automatic take_le_byte(input logic [7:0] b);
        if (m_le_seen == 2'd0) begin
            m_le      = {9'd0, b};
            m_le_seen = 2'd1;
        end else if (m_le_seen == 2'd1) begin
            m_le      = {1'b0, m_le[7:0], b};
            if (m_le[15:0] == 16'd0)
                m_le = CAP_LE_ZERO_LEN;
            m_le_seen = 2'd2;
        end
    endtask

    task automatic queue_body_byte(input logic [7:0] b);
        result_t item;
        item            = '0;
        item.item_kind  = KIND_BODY;
        item.body_byte  = b;
        item.body_index = m_count;
        owe_result(item);
        m_count = m_count + 16'd1;
        if (m_count == m_lc)
            m_phase = PH_LE;
    endtask

    // works out the results of one accepted request byte
    task automatic parse_byte(input logic [7:0] b, input logic last);
        result_t item;
        logic    ok;
        logic    status;
        ok     = 1'b0;
        status = STATUS_NONE;
        case (m_phase)
            PH_HEADER: begin
                if (m_pos == 3'd0)
                    m_class_ok = (b == 8'd0);
                else
                    m_hdr = {m_hdr[15:0], b};
                m_pos = m_pos + 3'd1;
                if (m_pos >= 3'd4) begin
                    m_pos   = '0;
                    m_phase = m_class_ok ? PH_LC : PH_SKIP;
                    if (last) begin
                        ok     = m_class_ok;
                        status = m_class_ok ? STATUS_NONE : STATUS_BAD_CLASS;
                    end
                end
            end
            PH_LC: begin
                if (b != 8'd0) begin
                    m_lc    = {8'd0, b};
                    m_phase = PH_BODY;
                end else begin
                    m_phase = PH_LCX;
                    ok      = last;
                end
            end
            PH_LCX: begin
                if (m_pos == 3'd0) begin
                    m_held = {8'd0, b};
                    m_pos  = 3'd1;
                    if (last) begin
                        take_le_byte(b);
                        ok = 1'b1;
                    end
                end else if (m_pos == 3'd1) begin
                    m_held = {m_held[7:0], b};
                    m_pos  = 3'd2;
                    if (last) begin
                        take_le_byte(m_held[15:8]);
                        take_le_byte(m_held[7:0]);
                        ok = 1'b1;
                    end
                end else begin
                    // third byte after a zero lc: the held pair was an extended lc
                    m_lc  = m_held;
                    m_pos = '0;
                    if (m_lc == 16'd0) begin
                        m_phase = PH_LE;
                        take_le_byte(b);
                        ok = last;
                    end else begin
                        m_phase = PH_BODY;
                        queue_body_byte(b);
                        ok = last && m_phase == PH_LE;
                    end
                end
            end
            PH_BODY: begin
                queue_body_byte(b);
                ok = last && m_phase == PH_LE;
            end
            PH_LE: begin
                take_le_byte(b);
                ok = last;
            end
            default: status = STATUS_BAD_CLASS;
        endcase

        // summary closes the apdu and clears everything
        if (last) begin
            item             = '0;
            item.item_kind   = KIND_SUMMARY;
            item.parse_ok    = ok;
            item.status_code = status;
            if (ok) begin
                item.instruction      = m_hdr[23:16];
                item.param_one        = m_hdr[15:8];
                item.param_two        = m_hdr[7:0];
                item.body_length      = m_lc;
                item.max_response_len = m_le;
            end
            item.is_last = 1'b1;
            owe_result(item);
            clear_parser_state();
        end
    endtask

    // one request byte, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        apdus_sent++;
        frame.delete();
    endtask

    task automatic put_header(input logic [7:0] cla, input logic [7:0] ins,
                              input logic [7:0] p1, input logic [7:0] p2);
        add_byte(cla);
        add_byte(ins);
        add_byte(p1);
        add_byte(p2);
    endtask

    task automatic put_body(input int n);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom));
    endtask

    // le byte, zero more often than chance
    function automatic logic [7:0] le_byte();
        return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    endfunction

    function automatic string show(result_t r);
        return $sformatf({"kind %0d byte %02h index %0d ok %0d status %0d ins %02h ",
                          "p1 %02h p2 %02h lc %0d le %0d last %0d"},
                         r.item_kind, r.body_byte, r.body_index, r.parse_ok,
                         r.status_code, r.instruction, r.param_one, r.param_two,
                         r.body_length, r.max_response_len, r.is_last);
    endfunction

    // result receiver idling
    always @(posedge aclk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result checking against the oldest owed result
    result_t got;
    result_t want;
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.item_kind        = m_axis_tuser;
            got.body_byte        = m_axis_tdata[7:0];
            got.body_index       = m_axis_tdata[23:8];
            got.parse_ok         = m_axis_tdata[24];
            got.status_code      = m_axis_tdata[25];
            got.instruction      = m_axis_tdata[33:26];
            got.param_one        = m_axis_tdata[41:34];
            got.param_two        = m_axis_tdata[49:42];
            got.body_length      = m_axis_tdata[65:50];
            got.max_response_len = m_axis_tdata[82:66];
            got.is_last          = m_axis_tlast;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", show(got));
            end else begin
                want = pending_results.pop_front();
                if (got.item_kind !== want.item_kind || got.body_byte !== want.body_byte ||
                    got.body_index !== want.body_index || got.parse_ok !== want.parse_ok ||
                    got.status_code !== want.status_code ||
                    got.instruction !== want.instruction ||
                    got.param_one !== want.param_one || got.param_two !== want.param_two ||
                    got.body_length !== want.body_length ||
                    got.max_response_len !== want.max_response_len ||
                    got.is_last !== want.is_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
                if (want.item_kind == KIND_BODY)
                    body_checked++;
                else if (want.parse_ok)
                    summary_ok++;
                else
                    summary_failed++;
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // fewer than four bytes
    task automatic test_short_apdus();
        frame = '{8'hFF};
        send_frame();
        frame = '{8'h00, 8'h12, 8'h34};
        send_frame();
    endtask

    // header only, extreme header values
    task automatic test_header_fields();
        put_header(8'h00, 8'hFF, 8'h00, 8'hFF);
        send_frame();
        put_header(8'h00, 8'h00, 8'hFF, 8'h00);
        send_frame();
    endtask

    // nonzero class, alone and with trailing bytes to skip
    task automatic test_bad_class();
        put_header(8'h80, 8'hA4, 8'h04, 8'h00);
        send_frame();
        put_header(8'hFF, 8'h01, 8'h02, 8'h03);
        add_byte(8'h05);
        add_byte(8'hAA);
        send_frame();
    endtask

    // single nonzero byte after the header is lc without body
    task automatic test_lone_lc();
        put_header(8'h00, 8'h20, 8'h00, 8'h80);
        add_byte(8'h05);
        send_frame();
    endtask

    // zero lc followed by none, one or two bytes of le
    task automatic test_zero_lc();
        put_header(8'h00, 8'hB0, 8'h00, 8'h00);
        add_byte(8'h00);
        send_frame();
        put_header(8'h00, 8'hB0, 8'h00, 8'h00);
        add_byte(8'h00);
        add_byte(8'h7F);
        send_frame();
        put_header(8'h00, 8'hB0, 8'h00, 8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        send_frame();
    endtask

    // extended lc: zero, a short body, and a body longer than a short lc allows
    task automatic test_extended_lc();
        put_header(8'h00, 8'hD6, 8'h01, 8'h02);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'hFF);
        send_frame();
        put_header(8'h00, 8'hD6, 8'h00, 8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h02);
        put_body(2);
        add_byte(8'h00);
        add_byte(8'h00);
        send_frame();
        put_header(8'h00, 8'hD6, 8'h7F, 8'h80);
        add_byte(8'h00);
        add_byte(8'h01);
        add_byte(8'h01);
        put_body(257);
        add_byte(8'h80);
        send_frame();
    endtask

    // one-byte le of zero, two-byte le, and bytes after it ignored
    task automatic test_le_forms();
        put_header(8'h00, 8'h10, 8'h20, 8'h30);
        add_byte(8'h01);
        add_byte(8'h55);
        add_byte(8'h00);
        send_frame();
        put_header(8'h00, 8'h10, 8'h20, 8'h30);
        add_byte(8'h01);
        add_byte(8'h55);
        add_byte(8'h12);
        add_byte(8'h34);
        add_byte(8'hEE);
        add_byte(8'hFF);
        send_frame();
    endtask

    // body cut short, short and extended lc
    task automatic test_short_body();
        put_header(8'h00, 8'h01, 8'h02, 8'h03);
        add_byte(8'h03);
        put_body(2);
        send_frame();
        put_header(8'h00, 8'h01, 8'h02, 8'h03);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'hFF);
        put_body(3);
        send_frame();
    endtask

    // largest short lc with largest one-byte le
    task automatic test_full_short_body();
        put_header(8'h00, 8'hC3, 8'h5A, 8'hA5);
        add_byte(8'hFF);
        put_body(255);
        add_byte(8'hFF);
        send_frame();
    endtask

    // mostly well-formed apdus with random content, the rest broken or noise
    task automatic test_random_apdus(input int stop_at);
        int shape;
        int form;
        int lc;
        int n;
        while (bytes_sent < stop_at) begin
            shape = $urandom_range(0, 99);
            if (shape < 70) begin
                put_header(8'h00, 8'($urandom), 8'($urandom), 8'($urandom));
                form = $urandom_range(0, 4);
                n    = $urandom_range(0, 2);
                case (form)
                    0: n = 0;
                    1: begin
                        lc = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 255)
                                                          : $urandom_range(1, 16);
                        add_byte(8'(lc));
                        put_body(lc);
                    end
                    2: begin
                        lc = ($urandom_range(0, 39) == 0) ? $urandom_range(17, 700)
                                                          : $urandom_range(1, 24);
                        add_byte(8'h00);
                        add_byte(8'(lc >> 8));
                        add_byte(8'(lc));
                        put_body(lc);
                    end
                    3: begin
                        add_byte(8'h00);
                        add_byte(8'h00);
                        add_byte(8'h00);
                        if (n == 0)
                            n = 1;
                    end
                    default: add_byte(8'h00);
                endcase
                for (int i = 0; i < n; i++)
                    add_byte(le_byte());
                // trailing junk after a two-byte le
                if (n == 2 && $urandom_range(0, 7) == 0)
                    put_body($urandom_range(1, 3));
            end else if (shape < 80) begin
                put_header(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                           8'($urandom));
                put_body($urandom_range(0, 6));
            end else if (shape < 90) begin
                put_header(8'h00, 8'($urandom), 8'($urandom), 8'($urandom));
                if ($urandom_range(0, 1) == 0) begin
                    lc = $urandom_range(2, 255);
                    add_byte(8'(lc));
                end else begin
                    lc = $urandom_range(2, 65535);
                    add_byte(8'h00);
                    add_byte(8'(lc >> 8));
                    add_byte(8'(lc));
                end
                put_body($urandom_range(1, (lc > 9) ? 8 : lc - 1));
            end else begin
                put_body($urandom_range(1, 10));
                if ($urandom_range(0, 1) == 0)
                    frame[0] = 8'h00;
            end
            send_frame();
        end
    endtask

    // test sequence
    initial begin
        int random_start;
        clear_parser_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 33;
        recv_idle_pct = 71;
        test_short_apdus();
        test_header_fields();
        test_bad_class();
        test_lone_lc();
        test_zero_lc();
        test_extended_lc();
        test_le_forms();
        test_short_body();
        test_full_short_body();

        random_start = bytes_sent;
        test_random_apdus(random_start + RANDOM_BYTES / 3);
        send_idle_pct = 71;
        recv_idle_pct = 33;
        test_random_apdus(random_start + 2 * RANDOM_BYTES / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_apdus(random_start + RANDOM_BYTES);
        s_axis_tvalid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d request bytes in %0d apdus under three idling patterns",
                 bytes_sent, apdus_sent);
        $display("checked %0d body bytes, %0d good and %0d failed summaries",
                 body_checked, summary_ok, summary_failed);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cap_pkg.sv
rtl/core/cap_parse.sv
rtl/core/cap_out_fifo.sv
rtl/core/command_apdu_parser_unit.sv
bench/testbench.sv
